[src/ccbb_pkg.sv]
package ccbb_pkg;

   localparam int MAX_ORDER   = 16;
   localparam int NUM_CORNERS = 4;
   localparam int WALK_STEPS  = 8;

   typedef logic [31:0] addr_type;
   typedef logic [5:0]  len_type;
   typedef logic [15:0] coord_type;
   typedef logic [2:0]  csr_index_type;

   // Register indexes of the configuration port
   localparam csr_index_type CSR_CURVE_MODE  = 3'd0;
   localparam csr_index_type CSR_CROP_FIRST  = 3'd1;
   localparam csr_index_type CSR_CROP_LAST   = 3'd2;
   localparam csr_index_type CSR_PIXEL_SHIFT = 3'd3;
   localparam csr_index_type CSR_CURVE_ORDER = 3'd4;

   localparam logic MODE_HILBERT = 1'b0;
   localparam logic MODE_MORTON  = 1'b1;

   // Hilbert digit walk tables, indexed by {state, digit}
   localparam logic [15:0] HILB_X  = 16'h936C;
   localparam logic [15:0] HILB_Y  = 16'h39C6;
   localparam logic [31:0] HILB_ST = 32'h3E6B94C1;

   localparam addr_type DIAG_HILBERT = 32'hAAAAAAAA;
   localparam addr_type DIAG_MORTON  = 32'hFFFFFFFF;
   localparam addr_type ADDR_ONES    = 32'hFFFFFFFF;
   localparam addr_type ADDR_ONE     = 32'd1;
   localparam len_type  FULL_LEN     = 6'd32;

   typedef struct packed {
      logic       curve_mode;
      addr_type   crop_first;
      addr_type   crop_last;
      logic [5:0] pixel_shift;
      logic [4:0] curve_order;
   } cfg_type;

   typedef struct packed {
      logic                         in_range;
      addr_type [NUM_CORNERS-1:0]   corner;
   } corner_type;

   typedef struct packed {
      addr_type   digits;
      coord_type  x;
      coord_type  y;
      logic [1:0] st;
   } point_type;

   typedef struct packed {
      logic                         in_range;
      point_type [NUM_CORNERS-1:0]  pt;
   } walk_type;

   // One base-4 digit of the curve walk, most significant digit first.
   function automatic point_type walk_step(point_type p, logic mode);
      logic [1:0] dig;
      logic [3:0] row;
      point_type  q;
      dig      = p.digits[31:30];
      row      = {p.st, dig};
      q        = p;
      q.digits = {p.digits[29:0], 2'b00};
      if (mode == MODE_MORTON) begin
         q.x = {p.x[14:0], dig[0]};
         q.y = {p.y[14:0], dig[1]};
      end else begin
         q.x  = {p.x[14:0], HILB_X[row]};
         q.y  = {p.y[14:0], HILB_Y[row]};
         q.st = HILB_ST[{row, 1'b0} +: 2];
      end
      return q;
   endfunction

endpackage

[src/ccbb_if.sv]
interface ccbb_req_if import ccbb_pkg::*; ();
   logic     valid;
   logic     ready;
   addr_type prefix_address;
   len_type  prefix_length;

   modport source (output valid, output prefix_address, output prefix_length, input ready);
   modport sink (input valid, input prefix_address, input prefix_length, output ready);
endinterface

interface ccbb_rsp_if import ccbb_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      in_range;
   coord_type box_xmin;
   coord_type box_ymin;
   coord_type box_xmax;
   coord_type box_ymax;

   modport source (output valid, output in_range, output box_xmin, output box_ymin,
                   output box_xmax, output box_ymax, input ready);
   modport sink (input valid, input in_range, input box_xmin, input box_ymin,
                 input box_xmax, input box_ymax, output ready);
endinterface

interface ccbb_csr_if import ccbb_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   addr_type      data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[src/ccbb_corner.sv]
module ccbb_corner import ccbb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   output logic       in_ready,
   input  addr_type   in_addr,
   input  len_type    in_len,
   output logic       out_valid,
   input  logic       out_ready,
   output corner_type out_data
);

   logic       valid_ff;
   corner_type data_ff;
   corner_type data_in;
   len_type    len_c;
   len_type    sq_len;
   addr_type   last;
   addr_type   diag;
   addr_type   off;
   addr_type   half;
   logic       odd;

   always_comb begin
      len_c  = (in_len > FULL_LEN) ? FULL_LEN : in_len;
      last   = (len_c == FULL_LEN) ? in_addr : (in_addr | (ADDR_ONES >> len_c));
      odd    = len_c[0];
      sq_len = odd ? len_c + 6'd1 : len_c;
      diag   = (cfg.curve_mode == MODE_MORTON) ? DIAG_MORTON : DIAG_HILBERT;
      off    = (sq_len == FULL_LEN) ? '0 : (diag >> sq_len);
      // The second half of an odd prefix starts one half-size further on.
      half   = odd ? (ADDR_ONE << (5'd31 - len_c[4:0])) : '0;

      data_in.in_range  = !((in_addr < cfg.crop_first) || (last > cfg.crop_last));
      data_in.corner[0] = in_addr;
      data_in.corner[1] = in_addr + off;
      data_in.corner[2] = in_addr + half;
      data_in.corner[3] = in_addr + (half | off);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[src/ccbb_index.sv]
module ccbb_index import ccbb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   output logic       in_ready,
   input  corner_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output walk_type   out_data
);

   logic       valid_ff;
   walk_type   data_ff;
   walk_type   data_in;
   logic [4:0] ord;
   addr_type   mask;
   addr_type   offs;
   addr_type   pix;
   logic       in_crop;

   always_comb begin
      ord  = (cfg.curve_order > 5'(MAX_ORDER)) ? 5'(MAX_ORDER) : cfg.curve_order;
      mask = ~(ADDR_ONES << {ord, 1'b0});
      data_in.in_range = in_data.in_range;
      for (int i = 0; i < NUM_CORNERS; i++) begin
         in_crop = (in_data.corner[i] >= cfg.crop_first) &&
                   (in_data.corner[i] <= cfg.crop_last);
         offs    = in_data.corner[i] - cfg.crop_first;
         pix     = (cfg.pixel_shift >= FULL_LEN) ? '0 : (offs >> cfg.pixel_shift);
         // Leading zero digits leave x and y at zero and only swap the Hilbert state
         // between its first two values, so every point walks 16 digits. Starting from
         // the order's parity brings the state back to zero at the first real digit.
         data_in.pt[i].digits = in_crop ? (pix & mask) : '0;
         data_in.pt[i].x      = '0;
         data_in.pt[i].y      = '0;
         data_in.pt[i].st     = {1'b0, ord[0]};
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[src/ccbb_walk.sv]
module ccbb_walk import ccbb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     curve_mode,
   input  logic     in_valid,
   output logic     in_ready,
   input  walk_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output walk_type out_data
);

   logic     valid_ff;
   walk_type data_ff;
   walk_type data_in;

   always_comb begin
      data_in = in_data;
      for (int i = 0; i < NUM_CORNERS; i++) begin
         for (int k = 0; k < WALK_STEPS; k++) begin
            data_in.pt[i] = walk_step(data_in.pt[i], curve_mode);
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[src/ccbb_box.sv]
module ccbb_box import ccbb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  walk_type         in_data,
   ccbb_rsp_if.source       rsp
);

   logic      valid_ff;
   logic      range_ff;
   coord_type xmin_ff, ymin_ff, xmax_ff, ymax_ff;
   logic      range_in;
   coord_type xmin_in, ymin_in, xmax_in, ymax_in;
   coord_type xlo0, xlo1, xhi0, xhi1, ylo0, ylo1, yhi0, yhi1;

   always_comb begin
      xlo0 = (in_data.pt[0].x < in_data.pt[1].x) ? in_data.pt[0].x : in_data.pt[1].x;
      xlo1 = (in_data.pt[2].x < in_data.pt[3].x) ? in_data.pt[2].x : in_data.pt[3].x;
      xhi0 = (in_data.pt[0].x > in_data.pt[1].x) ? in_data.pt[0].x : in_data.pt[1].x;
      xhi1 = (in_data.pt[2].x > in_data.pt[3].x) ? in_data.pt[2].x : in_data.pt[3].x;
      ylo0 = (in_data.pt[0].y < in_data.pt[1].y) ? in_data.pt[0].y : in_data.pt[1].y;
      ylo1 = (in_data.pt[2].y < in_data.pt[3].y) ? in_data.pt[2].y : in_data.pt[3].y;
      yhi0 = (in_data.pt[0].y > in_data.pt[1].y) ? in_data.pt[0].y : in_data.pt[1].y;
      yhi1 = (in_data.pt[2].y > in_data.pt[3].y) ? in_data.pt[2].y : in_data.pt[3].y;
      range_in = in_data.in_range;
      if (in_data.in_range) begin
         xmin_in = (xlo0 < xlo1) ? xlo0 : xlo1;
         xmax_in = (xhi0 > xhi1) ? xhi0 : xhi1;
         ymin_in = (ylo0 < ylo1) ? ylo0 : ylo1;
         ymax_in = (yhi0 > yhi1) ? yhi0 : yhi1;
      end else begin
         xmin_in = '0;
         xmax_in = '0;
         ymin_in = '0;
         ymax_in = '0;
      end
   end

   assign in_ready     = !valid_ff || rsp.ready;
   assign rsp.valid    = valid_ff;
   assign rsp.in_range = range_ff;
   assign rsp.box_xmin = xmin_ff;
   assign rsp.box_ymin = ymin_ff;
   assign rsp.box_xmax = xmax_ff;
   assign rsp.box_ymax = ymax_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         range_ff <= range_in;
         xmin_ff  <= xmin_in;
         ymin_ff  <= ymin_in;
         xmax_ff  <= xmax_in;
         ymax_ff  <= ymax_in;
      end
   end

endmodule

[src/cidr_curve_bounding_box.sv]
// Bounding box of an IPv4 prefix on a Hilbert or Morton (Z-order) curve grid. Each request
// word carries a prefix address and length; each response word carries an in-range flag and
// the box corners xmin, ymin, xmax, ymax. A prefix that reaches outside the crop window
// (crop_first to crop_last) gives in_range low and an all-zero box. The block is a six-stage
// pipeline: input register, corner addresses, pixel index, two halves of the 16-digit curve
// walk (eight digits each), and the min/max response register. One word is accepted every
// clock cycle while the response side does not stall; back-pressure fills empty stages
// before the request side is held off. Configuration registers may only be written while
// no word is in flight; the configuration port is always ready.

module cidr_curve_bounding_box import ccbb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ccbb_req_if.sink    req_chan,
   ccbb_rsp_if.source  rsp_chan,
   ccbb_csr_if.sink    csr_chan
);

   // Configuration registers
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Input register
   logic     in_valid_ff;
   addr_type in_addr_ff;
   len_type  in_len_ff;

   // Pipeline handshakes between stages
   logic       corner_ready, corner_valid;
   corner_type corner_data;
   logic       index_ready, index_valid;
   walk_type   index_data;
   logic       walk_hi_ready, walk_hi_valid;
   walk_type   walk_hi_data;
   logic       walk_lo_ready, walk_lo_valid;
   walk_type   walk_lo_data;
   logic       box_ready;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_CURVE_MODE:  cfg_in.curve_mode  = csr_chan.data[0];
            CSR_CROP_FIRST:  cfg_in.crop_first  = csr_chan.data;
            CSR_CROP_LAST:   cfg_in.crop_last   = csr_chan.data;
            CSR_PIXEL_SHIFT: cfg_in.pixel_shift = csr_chan.data[5:0];
            CSR_CURVE_ORDER: cfg_in.curve_order = csr_chan.data[4:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.curve_mode  <= MODE_HILBERT;
         cfg_ff.crop_first  <= '0;
         cfg_ff.crop_last   <= ADDR_ONES;
         cfg_ff.pixel_shift <= 6'd8;
         cfg_ff.curve_order <= 5'd12;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The input register takes a new word whenever it is empty or being drained.
   assign req_chan.ready = !in_valid_ff || corner_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_addr_ff <= req_chan.prefix_address;
         in_len_ff  <= req_chan.prefix_length;
      end
   end

   // Range check and the up to four corner addresses of the prefix.
   ccbb_corner u_corner (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (in_valid_ff),
      .in_ready  (corner_ready),
      .in_addr   (in_addr_ff),
      .in_len    (in_len_ff),
      .out_valid (corner_valid),
      .out_ready (index_ready),
      .out_data  (corner_data)
   );

   // Crop, pixel shift and order mask give each corner's curve index.
   ccbb_index u_index (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (corner_valid),
      .in_ready  (index_ready),
      .in_data   (corner_data),
      .out_valid (index_valid),
      .out_ready (walk_hi_ready),
      .out_data  (index_data)
   );

   // Upper eight digits of the curve walk.
   ccbb_walk u_walk_hi (
      .clock      (clock),
      .reset      (reset),
      .curve_mode (cfg_ff.curve_mode),
      .in_valid   (index_valid),
      .in_ready   (walk_hi_ready),
      .in_data    (index_data),
      .out_valid  (walk_hi_valid),
      .out_ready  (walk_lo_ready),
      .out_data   (walk_hi_data)
   );

   // Lower eight digits of the curve walk.
   ccbb_walk u_walk_lo (
      .clock      (clock),
      .reset      (reset),
      .curve_mode (cfg_ff.curve_mode),
      .in_valid   (walk_hi_valid),
      .in_ready   (walk_lo_ready),
      .in_data    (walk_hi_data),
      .out_valid  (walk_lo_valid),
      .out_ready  (box_ready),
      .out_data   (walk_lo_data)
   );

   // Minimum and maximum over the corners into the response register.
   ccbb_box u_box (
      .clock    (clock),
      .reset    (reset),
      .in_valid (walk_lo_valid),
      .in_ready (box_ready),
      .in_data  (walk_lo_data),
      .rsp      (rsp_chan)
   );

endmodule

[src/ccbb_checker.sv]
module ccbb_checker import ccbb_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input logic      in_range,
   input coord_type box_xmin,
   input coord_type box_ymin,
   input coord_type box_xmax,
   input coord_type box_ymax
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_zero_box: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !in_range) |->
         (box_xmin == '0 && box_ymin == '0 && box_xmax == '0 && box_ymax == '0))
      else $error("out of range response with non-zero box");

   a_ordered_box: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && in_range) |-> (box_xmin <= box_xmax && box_ymin <= box_ymax))
      else $error("box minimum above maximum");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request held off without a stalled response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

bind cidr_curve_bounding_box ccbb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .in_range  (rsp_chan.in_range),
   .box_xmin  (rsp_chan.box_xmin),
   .box_ymin  (rsp_chan.box_ymin),
   .box_xmax  (rsp_chan.box_xmax),
   .box_ymax  (rsp_chan.box_ymax)
);

[tb/testbench.sv]
`timescale 1ns / 1ps

// Self-checking testbench for cidr_curve_bounding_box.
//
// Prefix words are driven into the request channel and every accepted word is passed to a
// scoreboard, which works out the expected bounding box from its own copy of the five
// configuration registers. Each response word is checked field by field against the oldest
// box still due. The configuration registers are only rewritten once the pipeline has
// drained, so the scoreboard's copy always matches what the block used for a given word.
module testbench;
   import ccbb_pkg::*;

   // One response word as the scoreboard holds it.
   typedef struct packed {
      logic      in_range;
      coord_type xmin;
      coord_type ymin;
      coord_type xmax;
      coord_type ymax;
   } box_word_t;

   // Predicts the box for each accepted prefix and checks the response words in order.
   class box_scoreboard;
      cfg_type   regs;
      box_word_t boxes_due[$];
      int        errors;
      int        prefixes_seen;
      int        boxes_checked;
      int        boxes_in_range;

      function new();
         regs.curve_mode  = MODE_HILBERT;
         regs.crop_first  = '0;
         regs.crop_last   = ADDR_ONES;
         regs.pixel_shift = 6'd8;
         regs.curve_order = 5'd12;
      endfunction

      function void write_register(csr_index_type idx, addr_type data);
         case (idx)
            CSR_CURVE_MODE:  regs.curve_mode  = data[0];
            CSR_CROP_FIRST:  regs.crop_first  = data;
            CSR_CROP_LAST:   regs.crop_last   = data;
            CSR_PIXEL_SHIFT: regs.pixel_shift = data[5:0];
            CSR_CURVE_ORDER: regs.curve_order = data[4:0];
            default: ;
         endcase
      endfunction

      // Grid position of one address: offset into the crop window, scaled down to pixels,
      // then walked two bits at a time from the most significant digit.
      function void map_point(addr_type a, output coord_type px, output coord_type py);
         addr_type    s;
         logic [1:0]  dig;
         logic [1:0]  st;
         logic [3:0]  row;
         int unsigned order;
         px = '0;
         py = '0;
         st = '0;
         if (a < regs.crop_first || a > regs.crop_last) return;
         s = a - regs.crop_first;
         s = (regs.pixel_shift >= 32) ? '0 : (s >> regs.pixel_shift);
         order = (regs.curve_order > MAX_ORDER) ? MAX_ORDER : regs.curve_order;
         for (int k = order; k > 0; k--) begin
            dig = s[2*(k-1) +: 2];
            if (regs.curve_mode == MODE_MORTON) begin
               px = {px[14:0], dig[0]};
               py = {py[14:0], dig[1]};
            end else begin
               row = {st, dig};
               px  = {px[14:0], HILB_X[row]};
               py  = {py[14:0], HILB_Y[row]};
               st  = HILB_ST[2*row +: 2];
            end
         end
      endfunction

      function box_word_t predict_box(addr_type addr, len_type len_field);
         addr_type    corner [NUM_CORNERS];
         addr_type    diag;
         addr_type    last;
         addr_type    half;
         coord_type   px;
         coord_type   py;
         int unsigned l;
         int unsigned n;
         box_word_t   b;
         l = (len_field > FULL_LEN) ? 32 : len_field;
         last = (l < 32) ? (addr | (ADDR_ONES >> l)) : addr;
         b = '0;
         if (addr < regs.crop_first || last > regs.crop_last) return b;
         diag = (regs.curve_mode == MODE_MORTON) ? DIAG_MORTON : DIAG_HILBERT;
         corner[0] = addr;
         n = 1;
         if (l < 32 && (l % 2) == 0) begin
            corner[1] = addr + (diag >> l);
            n = 2;
         end else if (l < 32) begin
            // An odd length is covered as two squares of the next even length.
            half      = addr + (ADDR_ONE << (31 - l));
            corner[1] = addr + (diag >> (l + 1));
            corner[2] = half;
            corner[3] = half + (diag >> (l + 1));
            n = 4;
         end
         b.in_range = 1'b1;
         for (int i = 0; i < n; i++) begin
            map_point(corner[i], px, py);
            if (i == 0) begin
               b.xmin = px;
               b.xmax = px;
               b.ymin = py;
               b.ymax = py;
            end else begin
               if (px < b.xmin) b.xmin = px;
               if (px > b.xmax) b.xmax = px;
               if (py < b.ymin) b.ymin = py;
               if (py > b.ymax) b.ymax = py;
            end
         end
         return b;
      endfunction

      function void note_prefix(addr_type addr, len_type len_field);
         boxes_due.push_back(predict_box(addr, len_field));
         prefixes_seen++;
      endfunction

      function void compare_field(string what, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
         end
      endfunction

      function void check_box(box_word_t got);
         box_word_t want;
         if (boxes_due.size() == 0) begin
            errors++;
            $display("%0t ns: response word with no prefix outstanding, got %0h",
                     $time, got);
            return;
         end
         want = boxes_due.pop_front();
         boxes_checked++;
         if (want.in_range) boxes_in_range++;
         compare_field("in_range", 32'(want.in_range), 32'(got.in_range));
         compare_field("box_xmin", 32'(want.xmin), 32'(got.xmin));
         compare_field("box_ymin", 32'(want.ymin), 32'(got.ymin));
         compare_field("box_xmax", 32'(want.xmax), 32'(got.xmax));
         compare_field("box_ymax", 32'(want.ymax), 32'(got.ymax));
      endfunction

      function int pending();
         return boxes_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   ccbb_req_if req_if ();
   ccbb_rsp_if rsp_if ();
   ccbb_csr_if csr_if ();

   cidr_curve_bounding_box uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   box_scoreboard sb;

   // When burst is set both sides run without idle cycles. A non-zero response hold asks
   // the response side to refuse words for that many cycles, once.
   bit burst;
   int rsp_hold_cycles;
   int settings_used;

   localparam int RANDOM_SETTINGS  = 16;
   localparam int WORDS_PER_SETTING = 50;

   // Directed prefixes, sent under the reset configuration: the whole space, single hosts,
   // the shortest and longest odd lengths, host bits left set, corner sums that wrap past
   // the top of the space, and lengths above 32.
   addr_type directed_addr [18] = '{
      32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0A000000, 32'h0A000000, 32'hC0A80100,
      32'hC0A80101, 32'h7F000001, 32'h80000000, 32'h00000000, 32'h0A0000FF, 32'h12345678,
      32'h12345678, 32'hFFFFFFF0, 32'h55555555, 32'hAAAAAAAA, 32'h01020304, 32'hFFFFFFFF
   };
   len_type directed_len [18] = '{
      6'd0,  6'd32, 6'd0,  6'd8,  6'd9,  6'd24,
      6'd31, 6'd32, 6'd1,  6'd1,  6'd24, 6'd40,
      6'd63, 6'd28, 6'd2,  6'd17, 6'd16, 6'd2
   };

   // Fixed register settings, covering both curves, narrow crop windows, a pixel shift of
   // zero, of 32 and above and an odd one, and curve orders of 0, 1, the maximum and above.
   cfg_type fixed_settings [8] = '{
      '{MODE_MORTON,  32'h00000000, 32'hFFFFFFFF, 6'd0,  5'd16},
      '{MODE_HILBERT, 32'h0A000000, 32'h0AFFFFFF, 6'd8,  5'd8},
      '{MODE_MORTON,  32'hC0A80000, 32'hC0A8FFFF, 6'd0,  5'd8},
      '{MODE_HILBERT, 32'h00000000, 32'hFFFFFFFF, 6'd32, 5'd16},
      '{MODE_MORTON,  32'h00000000, 32'hFFFFFFFF, 6'd63, 5'd31},
      '{MODE_HILBERT, 32'h00000000, 32'hFFFFFFFF, 6'd16, 5'd0},
      '{MODE_HILBERT, 32'h80000000, 32'hFFFFFFFE, 6'd1,  5'd1},
      '{MODE_MORTON,  32'h12345678, 32'hFFFFFFFF, 6'd7,  5'd17}
   };

   always #1 clock = ~clock;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid          = 1'b0;
      req_if.prefix_address = '0;
      req_if.prefix_length  = '0;
      rsp_if.ready          = 1'b0;
      csr_if.valid          = 1'b0;
      csr_if.index          = '0;
      csr_if.data           = '0;
   end

   // Every handshake is observed here, at the rising edge, before any register in the block
   // has taken its new value. Register writes update the scoreboard's copy at the same edge
   // at which the block takes them.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            sb.write_register(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready)
            sb.note_prefix(req_if.prefix_address, req_if.prefix_length);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_box('{rsp_if.in_range, rsp_if.box_xmin, rsp_if.box_ymin,
                           rsp_if.box_xmax, rsp_if.box_ymax});
      end
   end

   // Offers one prefix word after a random gap and returns once it has been taken. Valid is
   // left high so that a following word with no gap goes out on the very next cycle.
   task automatic send_prefix(addr_type addr, len_type len_field);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid          <= 1'b1;
      req_if.prefix_address <= addr;
      req_if.prefix_length  <= len_field;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Draws a prefix that mostly falls inside the current crop window, with the host bits
   // usually cleared; the rest are anywhere in the space, so that both sides of every
   // window edge are reached.
   task automatic send_random_prefix();
      addr_type        addr;
      int unsigned     len_field;
      int unsigned     pick;
      longint unsigned span;
      longint unsigned draw;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         len_field = $urandom_range(33, 63);
      else if (pick < 8)
         len_field = $urandom_range(0, 32);
      else
         len_field = $urandom_range(16, 32);
      if ($urandom_range(0, 4) != 0 && sb.regs.crop_first <= sb.regs.crop_last) begin
         span = longint'(sb.regs.crop_last) - longint'(sb.regs.crop_first) + 1;
         draw = {$urandom(), $urandom()};
         addr = sb.regs.crop_first + addr_type'(draw % span);
      end else begin
         addr = $urandom();
      end
      if ($urandom_range(0, 3) != 0 && len_field < 32)
         addr = addr & ~(ADDR_ONES >> len_field);
      send_prefix(addr, len_type'(len_field));
   endtask

   task automatic write_register(csr_index_type idx, addr_type data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic apply_settings(cfg_type c);
      write_register(CSR_CURVE_MODE,  addr_type'(c.curve_mode));
      write_register(CSR_CROP_FIRST,  c.crop_first);
      write_register(CSR_CROP_LAST,   c.crop_last);
      write_register(CSR_PIXEL_SHIFT, addr_type'(c.pixel_shift));
      write_register(CSR_CURVE_ORDER, addr_type'(c.curve_order));
      settings_used++;
   endtask

   // Stops offering words and waits until every box still due has come back.
   task automatic drain_pipeline();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Random settings: either the whole space, an arbitrary (possibly empty) window, or an
   // aligned block; pixel shifts are mostly even and small, orders mostly legal.
   function automatic cfg_type random_settings();
      cfg_type     c;
      int unsigned w;
      c.curve_mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: begin
            c.crop_first = '0;
            c.crop_last  = ADDR_ONES;
         end
         1: begin
            c.crop_first = $urandom();
            c.crop_last  = $urandom();
         end
         default: begin
            w = $urandom_range(8, 31);
            c.crop_first = addr_type'($urandom()) & (ADDR_ONES << w);
            c.crop_last  = c.crop_first | (ADDR_ONES >> (32 - w));
         end
      endcase
      if ($urandom_range(0, 3) == 0)
         c.pixel_shift = 6'($urandom_range(0, 63));
      else
         c.pixel_shift = 6'(2 * $urandom_range(0, 12));
      if ($urandom_range(0, 5) == 0)
         c.curve_order = 5'($urandom_range(0, 31));
      else
         c.curve_order = 5'($urandom_range(1, 16));
      return c;
   endfunction

   // The response side: a random stall before each word, none at all during bursts, and
   // one long hold-off when asked for, counted here in cycles.
   initial begin
      int stall;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0)
            stall = rsp_hold_cycles;
         else
            stall = burst ? 0 : $urandom_range(0, 10);
         rsp_hold_cycles = 0;
         if (stall > 0) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   initial begin
      sb = new();
      burst = 1'b0;
      rsp_hold_cycles = 0;
      settings_used = 1;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_addr[i])
         send_prefix(directed_addr[i], directed_len[i]);

      // Hold the response side off for a long stretch while words keep coming back to
      // back, so that the pipeline fills and the request side is held off in turn.
      rsp_hold_cycles = 250;
      burst = 1'b1;
      repeat (40) send_random_prefix();
      burst = 1'b0;
      drain_pipeline();

      for (int setting = 0; setting < RANDOM_SETTINGS; setting++) begin
         if (setting > 0) begin
            drain_pipeline();
            if (setting <= 8)
               apply_settings(fixed_settings[setting - 1]);
            else
               apply_settings(random_settings());
         end
         repeat (WORDS_PER_SETTING) begin
            if ($urandom_range(0, 15) == 0) burst = ~burst;
            send_random_prefix();
         end
      end

      burst = 1'b0;
      drain_pipeline();
      repeat (12) @(posedge clock);

      $display("summary: %0d prefixes checked under %0d register settings, %0d of them in range",
               sb.boxes_checked, settings_used, sb.boxes_in_range);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("mismatches: %0d, boxes still due: %0d", sb.errors, sb.pending());
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Hard limit: far beyond the slowest correct run.
   initial begin
      #400000;
      $display("timeout with %0d boxes still due", sb.pending());
      $display("testbench: FAIL");
      $finish;
   end

endmodule

[sim.f]
src/ccbb_pkg.sv
src/ccbb_if.sv
src/ccbb_corner.sv
src/ccbb_index.sv
src/ccbb_walk.sv
src/ccbb_box.sv
src/cidr_curve_bounding_box.sv
src/ccbb_checker.sv
tb/testbench.sv
